/* sv/feedback_echo_delay_unit_assert.svh */
// assertion macros for the feedback echo delay unit
`ifndef FEEDBACK_ECHO_DELAY_UNIT_ASSERT_SVH
`define FEEDBACK_ECHO_DELAY_UNIT_ASSERT_SVH

// same-cycle implication, checked on clk, off during rst
`define FED_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off during rst
`define FED_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/fed_pkg.sv */
// shared constants for the feedback echo delay unit
`default_nettype none

package fed_pkg;

  // field widths
  localparam int SAMPLE_W    = 16;
  localparam int FRAMES_W    = 17;
  localparam int WEIGHT_W    = 8;
  localparam int CHCOUNT_W   = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = FRAMES_W;

  // default sizes
  localparam int DEFAULT_DELAY_SAMPLES = 65536;
  localparam int DEFAULT_CHANNELS      = 8;

  // mixing arithmetic
  localparam int MIX_ONE    = 128;
  localparam int MIX_SHIFT  = 7;
  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;

  // register reset values
  localparam logic [WEIGHT_W-1:0]  RST_FEEDBACK_WEIGHT = 8'd64;
  localparam logic [FRAMES_W-1:0]  RST_DELAY_FRAMES    = 17'd0;
  localparam logic [CHCOUNT_W-1:0] RST_CHANNEL_COUNT   = 4'd2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FEEDBACK_WEIGHT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DELAY_FRAMES    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT   = 2'd2;

endpackage

`default_nettype wire

/* sv/feedback_echo_delay_unit.sv */
// feedback echo delay unit: ring memory, block control and mix stage
//
//  channel | valid / ready        | payload
//  --------+----------------------+----------------------------------------
//  in      | in_valid / in_ready  | live_sample, block_start, block_frames
//  out     | out_valid / out_ready| out_sample
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one sample per cycle unless out stalls or a clear pass runs; a result passes the mix stage and output registers
// the ring memory does one read and one write per cycle: read at accept, write at mix
// a write to the entry being read in the same cycle is forwarded from a holding register
// after reset, and after a change of delay_frames or channel_count, a clear pass that
// zeroes every ring entry runs with in_ready low; cfg_ready stays high
// a stalled out holds the mix stage and in_ready follows out_ready in the same cycle
`default_nettype none
`include "feedback_echo_delay_unit_assert.svh"

module feedback_echo_delay_unit #(
  parameter int MAX_DELAY_SAMPLES = fed_pkg::DEFAULT_DELAY_SAMPLES,
  parameter int MAX_CHANNELS      = fed_pkg::DEFAULT_CHANNELS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic signed [fed_pkg::SAMPLE_W-1:0] live_sample,
  input  wire logic                             block_start,
  input  wire logic [fed_pkg::FRAMES_W-1:0]     block_frames,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [fed_pkg::SAMPLE_W-1:0]   out_sample,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [fed_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [fed_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import fed_pkg::*;

  localparam int AW    = $clog2(MAX_DELAY_SAMPLES);
  localparam int RPW   = $clog2(MAX_DELAY_SAMPLES + 1);
  localparam int CW    = $clog2(MAX_CHANNELS + 1);
  localparam int CMPW  = ((FRAMES_W > RPW) ? FRAMES_W : RPW) + 1;
  localparam int PRODW = SAMPLE_W + WEIGHT_W + 2;
  localparam logic [AW-1:0] CLEAR_LAST = AW'(MAX_DELAY_SAMPLES - 1);

  // configuration registers
  logic [WEIGHT_W-1:0]  feedback_weight;
  logic [FRAMES_W-1:0]  delay_frames;
  logic [CHCOUNT_W-1:0] channel_count;

  // derived ring geometry
  logic [CW-1:0]  ch_eff, ch_eff_next;
  logic [RPW-1:0] ef, ef_next;
  logic [RPW-1:0] cap_tab [MAX_CHANNELS+1];
  logic [WEIGHT_W-1:0] fb_eff;

  // block bookkeeping
  logic            active, active_next;
  logic [RPW-1:0]  rp, rp_next;
  logic [RPW-1:0]  base, base_next;
  logic [AW-1:0]   addr, addr_next;
  logic [CW-1:0]   chan_cnt, chan_cnt_next;
  logic [FRAMES_W-1:0] frame_cnt, frame_cnt_next;
  logic [FRAMES_W-1:0] blk_frames, blk_frames_next;

  // values after the block start decision
  logic            act0;
  logic [RPW-1:0]  rp0, base0;
  logic [AW-1:0]   addr0;
  logic [CW-1:0]   cc0;
  logic [FRAMES_W-1:0] fc0, bf0;
  logic            restart, too_long, chan_last, blk_last;

  // clear pass
  logic          clearing;
  logic [AW-1:0] clear_cnt;
  logic          ring_clear;

  // handshakes
  logic cfg_acc, in_acc, s1_adv, s1_free;

  // ring memory
  logic [SAMPLE_W-1:0] ring_mem [MAX_DELAY_SAMPLES];
  logic                rd_en, wr_en;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic [SAMPLE_W-1:0] rd_data, wr_data;

  // mix stage
  logic                       s1_valid, s1_acc, s1_wr;
  logic signed [SAMPLE_W-1:0] s1_live;
  logic [WEIGHT_W-1:0]        s1_fb;
  logic [AW-1:0]              s1_addr;
  logic                       lw_valid;
  logic [AW-1:0]              lw_addr;
  logic signed [SAMPLE_W-1:0] lw_data;
  logic signed [SAMPLE_W-1:0] stored, mix;
  logic signed [SAMPLE_W:0]   diff;
  logic signed [WEIGHT_W:0]   fb_s;
  logic signed [PRODW-1:0]    prod, mix_sum, mix_bias, mix_adj, mix_q;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign s1_adv    = s1_valid && (!out_valid || out_ready);
  assign s1_free   = !s1_valid || s1_adv;
  assign in_ready  = !clearing && s1_free;
  assign in_acc    = in_valid && in_ready;

  // a ring change happens only when the written value differs
  assign ring_clear = cfg_acc &&
    (((cfg_index == REG_DELAY_FRAMES) && (cfg_data != delay_frames)) ||
     ((cfg_index == REG_CHANNEL_COUNT) &&
      (cfg_data[CHCOUNT_W-1:0] != channel_count)));

  // frames that fit the ring for each channel count
  assign cap_tab[0] = RPW'(MAX_DELAY_SAMPLES);
  for (genvar k = 1; k <= MAX_CHANNELS; k++) begin : g_cap
    localparam int unsigned CapFrames = MAX_DELAY_SAMPLES / k;
    assign cap_tab[k] = RPW'(CapFrames);
  end

  always_comb begin
    if (channel_count == '0) begin
      ch_eff_next = CW'(1);
    end else if (int'(channel_count) > MAX_CHANNELS) begin
      ch_eff_next = CW'(MAX_CHANNELS);
    end else begin
      ch_eff_next = CW'(channel_count);
    end
  end

  always_comb begin
    if (CMPW'(delay_frames) < CMPW'(cap_tab[ch_eff])) begin
      ef_next = RPW'(delay_frames);
    end else begin
      ef_next = cap_tab[ch_eff];
    end
  end

  // geometry settles long before the clear pass that follows any change ends
  always_ff @(posedge clk) begin
    ch_eff <= ch_eff_next;
    ef     <= ef_next;
  end

  assign fb_eff = (feedback_weight > WEIGHT_W'(MIX_ONE)) ? WEIGHT_W'(MIX_ONE)
                                                          : feedback_weight;

  // block start decision, then one sample step
  always_comb begin
    restart  = (CMPW'(block_frames) + CMPW'(rp)) > CMPW'(ef);
    too_long = CMPW'(ef) < CMPW'(block_frames);
    rp0   = rp;
    base0 = base;
    bf0   = blk_frames;
    act0  = active;
    addr0 = addr;
    fc0   = frame_cnt;
    cc0   = chan_cnt;
    if (block_start) begin
      if ((fb_eff == '0) || too_long) begin
        act0 = 1'b0;
      end else begin
        if (restart) begin
          rp0   = '0;
          base0 = '0;
        end
        bf0   = block_frames;
        act0  = (block_frames != '0);
        addr0 = AW'(base0);
        fc0   = '0;
        cc0   = '0;
      end
    end

    chan_last = (CW'(cc0 + 1'b1) == ch_eff);
    blk_last  = chan_last && (FRAMES_W'(fc0 + 1'b1) == bf0);

    rp_next         = rp0;
    base_next       = base0;
    blk_frames_next = bf0;
    active_next     = act0;
    addr_next       = addr0;
    frame_cnt_next  = fc0;
    chan_cnt_next   = cc0;
    if (act0) begin
      addr_next = AW'(addr0 + 1'b1);
      if (chan_last) begin
        chan_cnt_next  = '0;
        frame_cnt_next = FRAMES_W'(fc0 + 1'b1);
      end else begin
        chan_cnt_next = CW'(cc0 + 1'b1);
      end
      if (blk_last) begin
        active_next = 1'b0;
        rp_next     = RPW'(rp0 + RPW'(bf0));
        base_next   = RPW'(RPW'(addr0) + 1'b1);
      end
    end
  end

  // configuration, block state and clear pass
  always_ff @(posedge clk) begin
    if (rst) begin
      feedback_weight <= RST_FEEDBACK_WEIGHT;
      delay_frames    <= RST_DELAY_FRAMES;
      channel_count   <= RST_CHANNEL_COUNT;
      clearing        <= 1'b1;
      clear_cnt       <= '0;
      active          <= 1'b0;
      rp              <= '0;
      base            <= '0;
      addr            <= '0;
      chan_cnt        <= '0;
      frame_cnt       <= '0;
      blk_frames      <= '0;
      lw_valid        <= 1'b0;
    end else begin
      if (cfg_acc) begin
        case (cfg_index)
          REG_FEEDBACK_WEIGHT: feedback_weight <= cfg_data[WEIGHT_W-1:0];
          REG_DELAY_FRAMES:    delay_frames    <= cfg_data;
          REG_CHANNEL_COUNT:   channel_count   <= cfg_data[CHCOUNT_W-1:0];
          default: begin
          end
        endcase
      end
      if (ring_clear) begin
        clearing  <= 1'b1;
        clear_cnt <= '0;
        active    <= 1'b0;
        rp        <= '0;
        base      <= '0;
        lw_valid  <= 1'b0;
      end else begin
        if (clearing) begin
          clear_cnt <= AW'(clear_cnt + 1'b1);
          if (clear_cnt == CLEAR_LAST) begin
            clearing <= 1'b0;
          end
        end
        if (in_acc) begin
          active     <= active_next;
          rp         <= rp_next;
          base       <= base_next;
          addr       <= addr_next;
          chan_cnt   <= chan_cnt_next;
          frame_cnt  <= frame_cnt_next;
          blk_frames <= blk_frames_next;
        end
        if (s1_wr) begin
          lw_valid <= 1'b1;
        end
      end
    end
  end

  // ring memory ports
  assign rd_en   = in_acc && act0;
  assign rd_addr = addr0;
  assign s1_wr   = s1_adv && s1_acc;
  assign wr_en   = clearing || s1_wr;
  assign wr_addr = clearing ? clear_cnt : s1_addr;
  assign wr_data = clearing ? '0 : mix;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= ring_mem[rd_addr];
    end
  end

  // mix stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_acc  <= act0;
      s1_live <= live_sample;
      s1_fb   <= fb_eff;
      s1_addr <= addr0;
    end
    if (s1_wr) begin
      lw_addr <= s1_addr;
      lw_data <= mix;
    end
  end

  // last write lands on the same edge as the read, so it is forwarded here
  assign stored = (lw_valid && (lw_addr == s1_addr)) ? lw_data : $signed(rd_data);

  // stored*fb + live*(128-fb) rewritten as live*128 + (stored-live)*fb
  always_comb begin
    diff     = {stored[SAMPLE_W-1], stored} - {s1_live[SAMPLE_W-1], s1_live};
    fb_s     = {1'b0, s1_fb};
    prod     = PRODW'(diff) * PRODW'(fb_s);
    mix_sum  = prod + (PRODW'(s1_live) <<< MIX_SHIFT);
    // round toward zero on negative sums
    mix_bias = mix_sum[PRODW-1] ? PRODW'(MIX_ONE - 1) : PRODW'(0);
    mix_adj  = mix_sum + mix_bias;
    mix_q    = mix_adj >>> MIX_SHIFT;
    if (mix_q > PRODW'(SAMPLE_MAX)) begin
      mix = SAMPLE_W'(SAMPLE_MAX);
    end else if (mix_q < PRODW'(SAMPLE_MIN)) begin
      mix = SAMPLE_W'(SAMPLE_MIN);
    end else begin
      mix = mix_q[SAMPLE_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_sample <= s1_acc ? stored : s1_live;
    end
  end

  `FED_ASSERT_NEXT(a_read_reaches_mix, rd_en, s1_valid && s1_acc, "ring read lost before mix")
  `FED_ASSERT_NEXT(a_mix_holds, s1_valid && !s1_adv, s1_valid && $stable(s1_addr), "mix stage moved while stalled")
  `FED_ASSERT_NOW(a_block_in_ring, active, (CMPW'(rp) + CMPW'(blk_frames)) <= CMPW'(ef), "open block runs past the ring")
  `FED_ASSERT_NEXT(a_clear_ends, clearing && (clear_cnt == CLEAR_LAST) && !ring_clear, !clearing, "clear pass overran")

endmodule

`default_nettype wire

/* sim/testbench.sv */
// testbench for the feedback echo delay unit: directed request table, then random blocks
`timescale 1ns / 100ps

module testbench;
  import fed_pkg::*;

  localparam int RING_DEPTH = DEFAULT_DELAY_SAMPLES;
  localparam int CH_LIMIT = DEFAULT_CHANNELS;
  localparam int LATENCY = 2;
  localparam int PHASES = 4;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int RUN_LIMIT_NS = 36_000_000;
  // no register sits behind this index
  localparam logic [CFG_INDEX_W-1:0] REG_NONE = 2'd3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [FRAMES_W-1:0] frames_t;
  typedef logic [CFG_INDEX_W-1:0] reg_index_t;
  typedef logic [CFG_DATA_W-1:0] reg_word_t;
  typedef enum logic {ROW_SAMPLE, ROW_REG} row_kind_t;
  typedef struct {
    row_kind_t  kind;
    reg_index_t idx;
    reg_word_t  data;
    logic       start;
    frames_t    frames;
    sample_t    live;
    bit         typed;
    sample_t    want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  sample_t live_sample = '0;
  logic block_start = 1'b0;
  frames_t block_frames = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sample_t out_sample;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  reg_index_t cfg_index = '0;
  reg_word_t cfg_data = '0;

  // echo line state as the design should hold it
  sample_t echo_ring [RING_DEPTH];
  int unsigned ring_pos, blk_frames, blk_samples, blk_done;
  bit blk_active;
  logic [WEIGHT_W-1:0] weight_reg;
  frames_t delay_reg;
  logic [CHCOUNT_W-1:0] chans_reg;

  sample_t echo_expect_q [$];
  plan_row_t plan [$];
  int unsigned fail_count = 0;
  int unsigned sent_count = 0;
  int unsigned send_gap_max = 15;
  int unsigned recv_gap_max = 15;

  feedback_echo_delay_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .live_sample  (live_sample),
    .block_start  (block_start),
    .block_frames (block_frames),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_sample   (out_sample),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned eff_chans();
    if (chans_reg == 0) return 1;
    if (chans_reg > CH_LIMIT) return CH_LIMIT;
    return chans_reg;
  endfunction

  function automatic int unsigned eff_ring_frames();
    int unsigned cap;
    cap = RING_DEPTH / eff_chans();
    return (delay_reg < cap) ? delay_reg : cap;
  endfunction

  function automatic int eff_weight();
    return (weight_reg > MIX_ONE) ? MIX_ONE : int'(weight_reg);
  endfunction

  function automatic void clear_echo();
    foreach (echo_ring[i]) echo_ring[i] = '0;
    ring_pos = 0;
    blk_frames = 0;
    blk_samples = 0;
    blk_done = 0;
    blk_active = 1'b0;
  endfunction

  function automatic sample_t echo_predict(input logic start, input frames_t frames,
                                           input sample_t live);
    int unsigned ch, addr;
    int fb, stored, mix;
    ch = eff_chans();
    if (start) begin
      if (eff_weight() == 0 || eff_ring_frames() < frames) begin
        blk_active = 1'b0;
      end else begin
        // a block that would run past the ring end starts over at the front
        if (frames + ring_pos > eff_ring_frames()) ring_pos = 0;
        blk_frames = frames;
        blk_samples = frames * ch;
        blk_done = 0;
        blk_active = (blk_samples != 0);
      end
    end
    addr = ring_pos * ch + blk_done;
    if (!blk_active || addr >= RING_DEPTH) return live;
    fb = eff_weight();
    stored = echo_ring[addr];
    mix = (stored * fb + int'(live) * (MIX_ONE - fb)) / MIX_ONE;
    if (mix > SAMPLE_MAX) mix = SAMPLE_MAX;
    else if (mix < SAMPLE_MIN) mix = SAMPLE_MIN;
    echo_ring[addr] = sample_t'(mix);
    blk_done++;
    if (blk_done >= blk_samples) begin
      ring_pos += blk_frames;
      blk_active = 1'b0;
    end
    return sample_t'(stored);
  endfunction

  function automatic sample_t rand_live();
    case ($urandom_range(0, 9))
      0: return sample_t'(SAMPLE_MAX);
      1: return sample_t'(SAMPLE_MIN);
      2: return '0;
      3: return '1;
      default: return sample_t'($urandom);
    endcase
  endfunction

  // weight in the low byte, junk above it that the register must drop
  function automatic reg_word_t rand_weight_word();
    reg_word_t w;
    w = reg_word_t'($urandom);
    case ($urandom_range(0, 9))
      0: w[WEIGHT_W-1:0] = '0;
      1: w[WEIGHT_W-1:0] = WEIGHT_W'(MIX_ONE);
      2: w[WEIGHT_W-1:0] = WEIGHT_W'($urandom_range(MIX_ONE + 1, 255));
      default: w[WEIGHT_W-1:0] = WEIGHT_W'($urandom_range(1, MIX_ONE - 1));
    endcase
    return w;
  endfunction

  function automatic void row_reg(input reg_index_t idx, input reg_word_t data);
    plan.push_back('{kind: ROW_REG, idx: idx, data: data, start: 1'b0, frames: '0,
                     live: '0, typed: 1'b0, want: '0});
  endfunction

  function automatic void row_smp(input logic start, input frames_t frames, input sample_t live,
                                  input bit typed = 1'b0, input sample_t want = '0);
    plan.push_back('{kind: ROW_SAMPLE, idx: '0, data: '0, start: start, frames: frames,
                     live: live, typed: typed, want: want});
  endfunction

  task automatic send_sample(input logic start, input frames_t frames, input sample_t live,
                             input bit typed = 1'b0, input sample_t want = '0);
    int unsigned gap;
    sample_t predicted;
    gap = $urandom_range(0, send_gap_max);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    live_sample <= live;
    block_start <= start;
    block_frames <= frames;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = echo_predict(start, frames, live);
    echo_expect_q.push_back(typed ? want : predicted);
    sent_count++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (echo_expect_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input reg_word_t data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_FEEDBACK_WEIGHT: weight_reg = data[WEIGHT_W-1:0];
      REG_DELAY_FRAMES: begin
        if (data[FRAMES_W-1:0] != delay_reg) begin
          delay_reg = data[FRAMES_W-1:0];
          clear_echo();
        end
      end
      REG_CHANNEL_COUNT: begin
        if (data[CHCOUNT_W-1:0] != chans_reg) begin
          chans_reg = data[CHCOUNT_W-1:0];
          clear_echo();
        end
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly complete blocks, some cut short, overrun, bypassed or empty
  task automatic send_block();
    int unsigned ch, ef, kind, frames_n, count;
    frames_t frames;
    ch = eff_chans();
    ef = eff_ring_frames();
    kind = $urandom_range(0, 15);
    count = 0;
    frames = '0;
    if (kind <= 11) begin
      if (ef == 0) frames_n = 1;
      else if (kind == 11) frames_n = $urandom_range(1, ef);
      else frames_n = $urandom_range(1, (ef < 6) ? ef : 6);
      frames = frames_t'(frames_n);
      count = frames_n * ch;
      if (count > 8 && kind == 11) count = $urandom_range(1, 8);
      case ($urandom_range(0, 7))
        0: count = $urandom_range(1, count);
        1: count = count + $urandom_range(1, 4);
        default: ;
      endcase
    end else if (kind == 12) begin
      frames = frames_t'($urandom_range(ef + 1, 131071));
      count = $urandom_range(1, 4);
    end else if (kind == 13) begin
      count = $urandom_range(1, 3);
    end else begin
      frames = frames_t'($urandom);
      count = $urandom_range(1, 4);
    end
    for (int k = 0; k < count; k++) begin
      send_sample(k == 0 && kind != 14, (k == 0) ? frames : frames_t'($urandom), rand_live());
    end
  endtask

  initial begin : out_side
    int unsigned stall;
    forever begin
      stall = $urandom_range(0, recv_gap_max);
      @(negedge clk);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid === 1'b1 && !rst)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_out
    sample_t want;
    if (!rst && out_valid && out_ready) begin
      if (echo_expect_q.size() == 0) begin
        $display("%0t out_sample: expected nothing, got %0d", $time, out_sample);
        fail_count++;
      end else begin
        want = echo_expect_q.pop_front();
        if (out_sample !== want) begin
          $display("%0t out_sample: expected %0d, got %0d", $time, want, out_sample);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int unsigned target;
    weight_reg = RST_FEEDBACK_WEIGHT;
    delay_reg = RST_DELAY_FRAMES;
    chans_reg = RST_CHANNEL_COUNT;
    clear_echo();

    // zero-length ring after reset: every request passes straight through
    row_smp(1'b1, 17'd1, 16'sh7fff, 1'b1, 16'sh7fff);
    row_smp(1'b0, 17'd0, -16'sh8000, 1'b1, -16'sh8000);
    row_smp(1'b1, 17'd0, 16'sh1234, 1'b1, 16'sh1234);
    row_smp(1'b1, 17'd131071, -16'sh0001, 1'b1, -16'sh0001);
    row_reg(REG_DELAY_FRAMES, 17'd3);
    row_smp(1'b1, 17'd1, 16'sh7fff);
    row_smp(1'b0, 17'h1ffff, -16'sh8000);
    row_smp(1'b0, 17'd0, 16'sd100);
    row_smp(1'b1, 17'd3, 16'sd1);
    row_reg(REG_FEEDBACK_WEIGHT, 17'd200);
    row_smp(1'b0, 17'd0, 16'sd5);
    row_reg(REG_FEEDBACK_WEIGHT, 17'd0);
    row_smp(1'b0, 17'd0, -16'sd7);
    row_reg(REG_FEEDBACK_WEIGHT, 17'd128);
    row_smp(1'b1, 17'd3, 16'sd0);
    row_smp(1'b0, 17'd0, 16'sd0);
    row_reg(REG_CHANNEL_COUNT, 17'd0);
    row_smp(1'b1, 17'd3, 16'sh7fff, 1'b1, 16'sd0);
    row_smp(1'b0, 17'd0, -16'sh8000);
    row_reg(REG_CHANNEL_COUNT, 17'd15);
    row_reg(REG_DELAY_FRAMES, 17'd131071);
    row_smp(1'b1, 17'd8193, 16'sd77, 1'b1, 16'sd77);
    row_smp(1'b1, 17'd8192, -16'sh8000, 1'b1, 16'sd0);
    row_smp(1'b0, 17'd0, 16'sh7fff);
    row_reg(REG_DELAY_FRAMES, 17'd131071);
    row_reg(REG_NONE, 17'h1ffff);
    row_reg(REG_FEEDBACK_WEIGHT, 17'h1ff81);
    row_smp(1'b0, 17'd0, 16'sd1234);
    row_reg(REG_FEEDBACK_WEIGHT, 17'd1);
    row_smp(1'b1, 17'd1, 16'sh7fff);
    row_smp(1'b0, 17'd0, -16'sh8000);
    row_smp(1'b0, 17'd0, 16'sh5555);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_sample(plan[i].start, plan[i].frames, plan[i].live, plan[i].typed, plan[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_reg(REG_FEEDBACK_WEIGHT, rand_weight_word());
      case (p)
        0: begin
          write_reg(REG_DELAY_FRAMES, 17'd65536);
          write_reg(REG_CHANNEL_COUNT, 17'd1);
        end
        1: begin
          write_reg(REG_DELAY_FRAMES, reg_word_t'($urandom_range(1, 40)));
          write_reg(REG_CHANNEL_COUNT, 17'd8);
        end
        default: begin
          write_reg(REG_DELAY_FRAMES, reg_word_t'($urandom_range(1, 40)));
          write_reg(REG_CHANNEL_COUNT, reg_word_t'($urandom_range(0, 15)));
        end
      endcase
      target = sent_count + ITEMS_PER_PHASE;
      while (sent_count < target) begin
        if ($urandom_range(0, 15) == 0) send_gap_max = $urandom_range(0, 1) ? 15 : 0;
        if ($urandom_range(0, 15) == 0) recv_gap_max = $urandom_range(0, 1) ? 15 : 0;
        // drain mid-phase, sometimes leaving a block open across a weight change
        if ($urandom_range(0, 39) == 0) begin
          wait_idle();
          if ($urandom_range(0, 1)) write_reg(REG_FEEDBACK_WEIGHT, rand_weight_word());
        end
        send_block();
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* feedback_echo_delay_unit.f */
+incdir+sv
sv/fed_pkg.sv
sv/feedback_echo_delay_unit.sv
sim/testbench.sv
